// ===== sv/jafe_pkg.sv =====
// shared types and constants for the joystick axis frame encoder
// no dependencies
package jafe_pkg;

    localparam int WINDOW_LEN_DEF = 5;
    localparam int NUM_AXES_DEF   = 2;

    localparam int SAMPLE_W = 12;
    localparam int BYTE_W   = 8;

    localparam logic [SAMPLE_W-1:0] CENTRE     = 12'd2047;
    localparam logic [BYTE_W-1:0]   FULL_SCALE = 8'd255;

    localparam logic [BYTE_W-1:0] AXIS_TAG       = 8'hAA;
    localparam logic [BYTE_W-1:0] BUTTON_TAG     = 8'hBB;
    localparam logic [BYTE_W-1:0] END_MARK       = 8'hFF;
    localparam logic [BYTE_W-1:0] DEADZONE_RESET = 8'd30;

    localparam logic REQ_AXIS   = 1'b0;
    localparam logic REQ_BUTTON = 1'b1;

    // floor(x / 2047) for x < 2**19 as (x * SCALE_MUL) >> SCALE_SH
    localparam int PROD_W      = 19;
    localparam int SCALE_MUL_W = 20;
    localparam int SCALE_SH    = 30;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 20'd524545;

    localparam int FRAME_LEN = 5;
    localparam int IDX_W     = 3;
    localparam logic [IDX_W-1:0] IDX_FIRST = 3'd0;
    localparam logic [IDX_W-1:0] IDX_LAST  = 3'(FRAME_LEN - 1);

    typedef struct packed {
        logic              btn;
        logic              axis;
        logic [BYTE_W-1:0] bid;
        logic              bst;
    } t_req;

endpackage

// ===== sv/joystick_axis_frame_encoder.sv =====
// joystick axis frame encoder: moving average, scaling, deadzone and byte framing
// depends on jafe_pkg
//
//   channel   direction  handshake                       payload
//   in        input      i_in_valid / o_in_stall         req_type, axis, sample, btn_code,
//                                                        button_state
//   out       output     o_out_valid / i_out_stall       frame_byte, frame_last
//   cfg       input      i_cfg_wr_en                     i_cfg_wr_data (deadzone)
//
// an item's first frame byte is valid once the item has passed the four pipeline stages
// (r1 to r4) and been loaded into the frame register; each item yields five bytes, one per
// cycle while the output is not stalled, so the byte serializer limits the sustained rate,
// while the pipeline can take new items until all of its stages are full.
// reset clears the sample windows and running sums and sets deadzone to 30.
// a stall on the output holds the frame register and backs up the pipeline to the input;
// a sample for an axis index of NUM_AXES or above is taken and dropped.
module joystick_axis_frame_encoder
    import jafe_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int NUM_AXES   = NUM_AXES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [BYTE_W-1:0]   i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_req_type,
    input  logic                i_axis,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [BYTE_W-1:0]   i_btn_code,
    input  logic                i_button_state,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [BYTE_W-1:0]   o_frame_byte,
    output logic                o_frame_last
);

    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int DIV_SH  = SUM_W + $clog2(WINDOW_LEN);
    localparam int DIV_MUL = ((1 << DIV_SH) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [SUM_W:0] DIV_MUL_V = (SUM_W+1)'(DIV_MUL);
    localparam int AX_IW   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(WINDOW_LEN * 4095);

    logic [BYTE_W-1:0]   r_deadzone;
    logic [SAMPLE_W-1:0] r_win [NUM_AXES][WINDOW_LEN];
    logic [SUM_W-1:0]    r_sum [NUM_AXES];

    logic                r1_v, r2_v, r3_v, r4_v;
    t_req                r1_req, r2_req, r3_req, r4_req;
    logic [SUM_W-1:0]    r1_sum;
    logic [SAMPLE_W-1:0] r2_avg;
    logic [PROD_W-1:0]   r3_prod;
    logic                r3_neg, r4_neg;
    logic [BYTE_W-1:0]   r4_mag;

    logic                r_out_v;
    logic [IDX_W-1:0]    r_idx;
    logic [BYTE_W-1:0]   r_bytes [FRAME_LEN];

    logic                in_acc, axis_ok, win_we, s1_in;
    logic [AX_IW-1:0]    axis_idx;
    logic [SUM_W:0]      sum_ext;
    logic [SUM_W-1:0]    n_sum;
    logic                en1, en2, en3, en4, ld, out_done;
    t_req                in_req;
    logic [2*SUM_W:0]    avg_prod;
    logic [SAMPLE_W-1:0] avg;
    logic [SAMPLE_W-1:0] absd;
    logic                neg;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W+SCALE_MUL_W-1:0] q_prod;
    logic [PROD_W+SCALE_MUL_W-SCALE_SH-1:0] q;
    logic [BYTE_W-1:0]   mag, kept;
    logic [15:0]         word;
    logic [BYTE_W-1:0]   n_bytes [FRAME_LEN];

    // flow control
    always_comb begin
        out_done   = r_out_v && !i_out_stall && (r_idx == IDX_LAST);
        ld         = !r_out_v || out_done;
        en4        = !r4_v || ld;
        en3        = !r3_v || en4;
        en2        = !r2_v || en3;
        en1        = !r1_v || en2;
        o_in_stall = !en1;
        in_acc     = i_in_valid && !o_in_stall;
    end

    // request decode and running sum
    always_comb begin
        axis_idx   = AX_IW'(i_axis);
        axis_ok    = 32'(i_axis) < NUM_AXES;
        win_we     = in_acc && (i_req_type == REQ_AXIS) && axis_ok;
        s1_in      = in_acc && ((i_req_type == REQ_BUTTON) || axis_ok);
        in_req.btn  = (i_req_type == REQ_BUTTON);
        in_req.axis = i_axis;
        in_req.bid  = i_btn_code;
        in_req.bst  = i_button_state;
        sum_ext = {1'b0, r_sum[axis_idx]} + (SUM_W+1)'(i_sample)
                  - (SUM_W+1)'(r_win[axis_idx][WINDOW_LEN-1]);
        n_sum   = sum_ext[SUM_W-1:0];
    end

    // average, centring, scaling, deadzone and frame build
    always_comb begin
        avg_prod = r1_sum * DIV_MUL_V;
        avg      = avg_prod[DIV_SH +: SAMPLE_W];

        neg  = r2_avg < CENTRE;
        absd = neg ? (CENTRE - r2_avg) : (r2_avg - CENTRE);
        prod = PROD_W'(absd) * PROD_W'(FULL_SCALE);

        q_prod = r3_prod * SCALE_MUL;
        q      = q_prod[PROD_W+SCALE_MUL_W-1:SCALE_SH];
        mag    = (q > 9'(FULL_SCALE)) ? FULL_SCALE : q[BYTE_W-1:0];

        kept = (r4_mag < r_deadzone) ? '0 : r4_mag;
        word = r4_neg ? (16'd0 - {8'd0, kept}) : {8'd0, kept};
        if (r4_req.btn) begin
            n_bytes[0] = BUTTON_TAG;
            n_bytes[1] = r4_req.bid;
            n_bytes[2] = {7'd0, r4_req.bst};
            n_bytes[3] = '0;
        end else begin
            n_bytes[0] = AXIS_TAG;
            n_bytes[1] = {7'd0, r4_req.axis};
            n_bytes[2] = word[15:8];
            n_bytes[3] = word[7:0];
        end
        n_bytes[4] = END_MARK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= DEADZONE_RESET;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_sum[a] <= '0;
                for (int k = 0; k < WINDOW_LEN; k++) begin
                    r_win[a][k] <= '0;
                end
            end
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_out_v <= 1'b0;
            r_idx   <= IDX_FIRST;
        end else begin
            if (i_cfg_wr_en) begin
                r_deadzone <= i_cfg_wr_data;
            end
            for (int a = 0; a < NUM_AXES; a++) begin
                if (win_we && (axis_idx == AX_IW'(a))) begin
                    r_sum[a]    <= n_sum;
                    r_win[a][0] <= i_sample;
                    for (int k = 1; k < WINDOW_LEN; k++) begin
                        r_win[a][k] <= r_win[a][k-1];
                    end
                end
            end
            if (en1) r1_v <= s1_in;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (ld) begin
                r_out_v <= r4_v;
                r_idx   <= IDX_FIRST;
            end else if (!i_out_stall) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_req <= in_req;
            r1_sum <= n_sum;
        end
        if (en2) begin
            r2_req <= r1_req;
            r2_avg <= avg;
        end
        if (en3) begin
            r3_req  <= r2_req;
            r3_prod <= prod;
            r3_neg  <= neg;
        end
        if (en4) begin
            r4_req <= r3_req;
            r4_mag <= mag;
            r4_neg <= r3_neg;
        end
        if (ld) begin
            for (int k = 0; k < FRAME_LEN; k++) begin
                r_bytes[k] <= n_bytes[k];
            end
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_frame_byte = r_bytes[r_idx];
    assign o_frame_last = (r_idx == IDX_LAST);

    a_first_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_idx == IDX_FIRST) |-> (o_frame_byte == AXIS_TAG ||
                                             o_frame_byte == BUTTON_TAG))
        else $error("frame does not open with a tag byte");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum[0] <= MAX_SUM)
        else $error("running sum out of range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r1_v && r2_v && r3_v && r4_v && r_out_v))
        else $error("input stalled with a free pipeline slot");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_done |=> (!r_out_v || r_idx == IDX_FIRST))
        else $error("next frame does not start at its first byte");

endmodule
